// ===== rtl/fsr_pkg.sv =====
`timescale 1ns / 1ps

package fsr_pkg;

	localparam int QB = 30;
	localparam logic [QB:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [15:0] REFL_ONE = 16'h8000;

	typedef struct packed {
		logic        tir;
		logic        refr;
		logic        n2zero;
		logic [QB:0] c;
	} div_side_t;

	typedef struct packed {
		logic        tir;
		logic        refr;
		logic [QB:0] c;
		logic [QB:0] r0;
	} sqrt_side_t;

	typedef struct packed {
		logic        tir;
		logic [QB:0] r0;
	} pow_side_t;

endpackage

// ===== rtl/fresnel_schlick_reflectance_top.sv =====
`timescale 1ns / 1ps

// Schlick Fresnel reflectance with total internal reflection. A beat is taken
// on any cycle with start high (busy is always low) and its result appears with
// done high; one beat per cycle is sustained. The path runs through the two
// 31-stage bit-per-stage units (the sin^2 and r0 dividers run side by side, then
// the square root) plus twelve arithmetic stages. done is a one-cycle strobe;
// the receiver cannot stall it.
module fresnel_schlick_reflectance_top #(
	parameter int VEC_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] eye_x,
	input  logic signed [15:0] eye_y,
	input  logic signed [15:0] eye_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [14:0]        index_from,
	input  logic [14:0]        index_to,
	output logic               done,
	output logic [15:0]        reflectance,
	output logic               total_internal
);

	localparam int QB  = fsr_pkg::QB;
	localparam int FB2 = 2 * VEC_FRAC_BITS;
	localparam int DW  = (FB2 + 2 > 34) ? FB2 + 2 : 34;
	localparam int SHR = (FB2 >= QB) ? FB2 - QB : 0;
	localparam int SHL = (FB2 >= QB) ? 0 : QB - FB2;
	localparam logic [DW-1:0] FULL = DW'(1) << FB2;

	assign busy = 1'b0;

	// stage 1: products
	logic               vld_s1, refr_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [29:0]        n1sq_s1, n2sq_s1;
	logic [14:0]        diff_s1;
	logic [15:0]        sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		px_s1   <= 32'(eye_x) * 32'(normal_x);
		py_s1   <= 32'(eye_y) * 32'(normal_y);
		pz_s1   <= 32'(eye_z) * 32'(normal_z);
		n1sq_s1 <= 30'(index_from) * 30'(index_from);
		n2sq_s1 <= 30'(index_to) * 30'(index_to);
		refr_s1 <= index_from > index_to;
		diff_s1 <= (index_from > index_to) ? index_from - index_to : index_to - index_from;
		sum_s1  <= 16'(index_from) + 16'(index_to);
	end

	// stage 2: dot product, clamp, bring to Q.30
	logic signed [DW-1:0] dot;
	logic [DW-1:0]        dcl;
	logic [DW+QB-1:0]     cw;
	logic                 vld_s2, refr_s2;
	logic [QB:0]          c_s2;
	logic [29:0]          n1sq_s2, n2sq_s2;
	logic [14:0]          diff_s2;
	logic [15:0]          sum_s2;

	always_comb begin
		dot = DW'(px_s1) + DW'(py_s1) + DW'(pz_s1);
		if (dot < 0)
			dcl = '0;
		else if (dot > $signed(FULL))
			dcl = FULL;
		else
			dcl = DW'(dot);
		cw = ((DW+QB)'(dcl) << SHL) >> SHR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		c_s2    <= cw[QB:0];
		refr_s2 <= refr_s1;
		n1sq_s2 <= n1sq_s1;
		n2sq_s2 <= n2sq_s1;
		diff_s2 <= diff_s1;
		sum_s2  <= sum_s1;
	end

	// stage 3: cos^2
	logic [2*QB+1:0] cc;
	logic            vld_s3, refr_s3;
	logic [QB:0]     c_s3, ccq_s3;
	logic [29:0]     n1sq_s3, n2sq_s3;
	logic [14:0]     diff_s3;
	logic [15:0]     sum_s3;

	assign cc = (2*QB+2)'(c_s2) * (2*QB+2)'(c_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		ccq_s3  <= cc[QB +: QB+1];
		c_s3    <= c_s2;
		refr_s3 <= refr_s2;
		n1sq_s3 <= n1sq_s2;
		n2sq_s3 <= n2sq_s2;
		diff_s3 <= diff_s2;
		sum_s3  <= sum_s2;
	end

	// stage 4: n1^2 * (1 - cos^2)
	logic [QB:0]  s_sin;
	logic         vld_s4, refr_s4;
	logic [60:0]  num_s4;
	logic [QB:0]  c_s4;
	logic [29:0]  n2sq_s4;
	logic [14:0]  diff_s4;
	logic [15:0]  sum_s4;

	assign s_sin = fsr_pkg::ONE_Q30 - ccq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		num_s4  <= 61'(n1sq_s3) * 61'(s_sin);
		c_s4    <= c_s3;
		refr_s4 <= refr_s3;
		n2sq_s4 <= n2sq_s3;
		diff_s4 <= diff_s3;
		sum_s4  <= sum_s3;
	end

	// stage 5: total internal reflection test
	logic         vld_s5;
	logic [60:0]  num_s5;
	logic [29:0]  n2sq_s5;
	logic [14:0]  diff_s5;
	logic [15:0]  sum_s5;
	fsr_pkg::div_side_t dside_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		num_s5          <= num_s4;
		n2sq_s5         <= n2sq_s4;
		diff_s5         <= diff_s4;
		sum_s5          <= sum_s4;
		dside_s5.tir    <= refr_s4 && (num_s4 > {1'b0, n2sq_s4, 30'b0});
		dside_s5.refr   <= refr_s4;
		dside_s5.n2zero <= n2sq_s4 == '0;
		dside_s5.c      <= c_s4;
	end

	// sin^2 and r0 quotients side by side
	logic               sin_vld, q_vld, q_zero;
	logic [QB:0]        sin2, qv;
	fsr_pkg::div_side_t dside;

	fsr_div_pipe #(.NW(61), .DVW(30), .QW(QB+1), .SW($bits(fsr_pkg::div_side_t))) u_div_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.num      (num_s5),
		.den      (n2sq_s5),
		.in_side  (dside_s5),
		.out_vld  (sin_vld),
		.quo      (sin2),
		.out_side (dside)
	);

	fsr_div_pipe #(.NW(45), .DVW(16), .QW(QB+1), .SW(1)) u_div_r0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.num      ({diff_s5, 30'b0}),
		.den      (sum_s5),
		.in_side  (sum_s5 == '0),
		.out_vld  (q_vld),
		.quo      (qv),
		.out_side (q_zero)
	);

	// stage 6: r0 and the square root radicand
	logic [2*QB+1:0]     qq;
	logic [QB:0]         sin2_eff;
	logic                vld_s6;
	logic [2*QB+1:0]     rad_s6;
	fsr_pkg::sqrt_side_t sside_s6;

	assign qq       = (2*QB+2)'(qv) * (2*QB+2)'(qv);
	assign sin2_eff = dside.n2zero ? '0 : sin2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= sin_vld;
	end

	always_ff @(posedge clk) begin
		rad_s6        <= {1'b0, fsr_pkg::ONE_Q30 - sin2_eff, 30'b0};
		sside_s6.tir  <= dside.tir;
		sside_s6.refr <= dside.refr;
		sside_s6.c    <= dside.c;
		sside_s6.r0   <= q_zero ? '0 : qq[QB +: QB+1];
	end

	logic                sq_vld;
	logic [QB:0]         root;
	fsr_pkg::sqrt_side_t sside;

	fsr_sqrt_pipe #(.NB(QB+1), .SW($bits(fsr_pkg::sqrt_side_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.rad      (rad_s6),
		.in_side  (sside_s6),
		.out_vld  (sq_vld),
		.root     (root),
		.out_side (sside)
	);

	// 1 - cos, raised to the fifth
	logic [QB:0]        xv;
	fsr_pkg::pow_side_t pside_in, pside;
	logic               pw_vld;
	logic [QB:0]        p5;

	assign xv           = fsr_pkg::ONE_Q30 - (sside.refr ? root : sside.c);
	assign pside_in.tir = sside.tir;
	assign pside_in.r0  = sside.r0;

	fsr_pow5 #(.SW($bits(fsr_pkg::pow_side_t))) u_pow5 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.x        (xv),
		.in_side  (pside_in),
		.out_vld  (pw_vld),
		.p5       (p5),
		.out_side (pside)
	);

	// stage 12: (1 - r0) * x^5
	logic [2*QB+1:0] tp;
	logic            vld_s12, tir_s12;
	logic [QB:0]     t_s12, r0_s12;

	assign tp = (2*QB+2)'(fsr_pkg::ONE_Q30 - pside.r0) * (2*QB+2)'(p5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s12 <= 1'b0;
		else
			vld_s12 <= pw_vld;
	end

	always_ff @(posedge clk) begin
		t_s12   <= tp[QB +: QB+1];
		r0_s12  <= pside.r0;
		tir_s12 <= pside.tir;
	end

	// stage 13: add, round half up into Q1.15, saturate
	logic [QB+1:0] rsum;
	logic [16:0]   rnd;
	logic          vld_s13, tir_s13;
	logic [15:0]   refl_s13;

	assign rsum = (QB+2)'(r0_s12) + (QB+2)'(t_s12) + (QB+2)'(1 << 14);
	assign rnd  = rsum[15 +: 17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s13 <= 1'b0;
		else
			vld_s13 <= vld_s12;
	end

	always_ff @(posedge clk) begin
		tir_s13 <= tir_s12;
		if (tir_s12 || rnd > 17'(fsr_pkg::REFL_ONE))
			refl_s13 <= fsr_pkg::REFL_ONE;
		else
			refl_s13 <= rnd[15:0];
	end

	assign done           = vld_s13;
	assign reflectance    = refl_s13;
	assign total_internal = tir_s13;

`ifndef SYNTH
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		sin_vld == q_vld)
		else $error("divider pipes out of step");

	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && total_internal |-> reflectance == fsr_pkg::REFL_ONE)
		else $error("total internal reflection without full reflectance");

	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> reflectance <= fsr_pkg::REFL_ONE)
		else $error("reflectance above one");

	a_tir_refr: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld && sside.tir |-> sside.refr)
		else $error("total internal reflection without a denser source");
`endif

endmodule

// ===== rtl/fsr_div_pipe.sv =====
`timescale 1ns / 1ps

module fsr_div_pipe #(
	parameter int NW  = 61,
	parameter int DVW = 30,
	parameter int QW  = 31,
	parameter int SW  = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  logic [NW-1:0]  num,
	input  logic [DVW-1:0] den,
	input  logic [SW-1:0]  in_side,
	output logic           out_vld,
	output logic [QW-1:0]  quo,
	output logic [SW-1:0]  out_side
);

	logic [NW-1:0]  rem_s  [QW];
	logic [DVW-1:0] den_s  [QW];
	logic [QW-1:0]  quo_s  [QW+1];
	logic [SW-1:0]  side_s [QW+1];
	logic           vld_s  [QW+1];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int B = QW - 1 - k;
		logic ge;
		assign ge = (rem_s[k] >> B) >= NW'(den_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			quo_s[k+1]  <= ge ? (quo_s[k] | (QW'(1) << B)) : quo_s[k];
			side_s[k+1] <= side_s[k];
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? rem_s[k] - (NW'(den_s[k]) << B) : rem_s[k];
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign out_side = side_s[QW];

endmodule

// ===== rtl/fsr_sqrt_pipe.sv =====
`timescale 1ns / 1ps

module fsr_sqrt_pipe #(
	parameter int NB = 31,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [2*NB-1:0] rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_vld,
	output logic [NB-1:0]   root,
	output logic [SW-1:0]   out_side
);

	localparam int RW = 2 * NB;

	logic [RW-1:0] v_s    [NB];
	logic [RW-1:0] res_s  [NB+1];
	logic [SW-1:0] side_s [NB+1];
	logic          vld_s  [NB+1];

	assign v_s[0]    = rad;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	// digit-by-digit root, one result bit per stage
	for (genvar k = 0; k < NB; k++) begin : g_st
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NB - 1 - k));
		logic [RW-1:0] t;
		logic          ge;
		assign t  = res_s[k] + BIT;
		assign ge = v_s[k] >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			res_s[k+1]  <= ge ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
			side_s[k+1] <= side_s[k];
		end

		if (k < NB - 1) begin : g_v
			always_ff @(posedge clk) begin
				v_s[k+1] <= ge ? v_s[k] - t : v_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NB];
	assign root     = res_s[NB][NB-1:0];
	assign out_side = side_s[NB];

endmodule

// ===== rtl/fsr_pow5.sv =====
`timescale 1ns / 1ps

module fsr_pow5 #(
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [fsr_pkg::QB:0] x,
	input  logic [SW-1:0]       in_side,
	output logic                out_vld,
	output logic [fsr_pkg::QB:0] p5,
	output logic [SW-1:0]       out_side
);

	localparam int W = fsr_pkg::QB + 1;

	logic [W-1:0]  p_s    [5];
	logic [W-1:0]  x_s    [4];
	logic [SW-1:0] side_s [5];
	logic          vld_s  [5];

	assign p_s[0]    = x;
	assign x_s[0]    = x;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	// four Q.30 products, each truncated
	for (genvar k = 0; k < 4; k++) begin : g_st
		logic [2*W-1:0] prod;
		assign prod = (2*W)'(p_s[k]) * (2*W)'(x_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			p_s[k+1]    <= prod[fsr_pkg::QB +: W];
			side_s[k+1] <= side_s[k];
		end

		if (k < 3) begin : g_x
			always_ff @(posedge clk) begin
				x_s[k+1] <= x_s[k];
			end
		end
	end

	assign out_vld  = vld_s[4];
	assign p5       = p_s[4];
	assign out_side = side_s[4];

endmodule

// ===== tb/tb_fresnel_schlick_reflectance_top.sv =====
`timescale 1ns / 1ps

module tb_fresnel_schlick_reflectance_top;

	localparam int VFB = 14;
	localparam int LATENCY = 74;

	typedef struct packed {
		logic [15:0] refl;
		logic        tir;
	} refl_beat_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] eye_x, eye_y, eye_z;
	logic signed [15:0] normal_x, normal_y, normal_z;
	logic [14:0] index_from, index_to;
	logic done;
	logic [15:0] reflectance;
	logic total_internal;

	refl_beat_t expected_refl[$];
	int errors = 0;

	fresnel_schlick_reflectance_top #(.VEC_FRAC_BITS(VFB)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.index_from(index_from), .index_to(index_to),
		.done(done), .reflectance(reflectance), .total_internal(total_internal)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_fresnel_schlick_reflectance_top: done, errors");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic refl_beat_t schlick_reflectance(
		logic signed [15:0] ex, logic signed [15:0] ey, logic signed [15:0] ez,
		logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
		logic [14:0] nfrom, logic [14:0] nto);
		longint dot;
		logic [63:0] d, c, s, num, lim, sin2, diff, sum, q, r0, x, p, res;
		logic [63:0] one, full, n1, n2;
		refl_beat_t r;
		one = 64'd1 << 30;
		full = 64'd1 << (2 * VFB);
		n1 = nfrom;
		n2 = nto;
		dot = longint'(ex) * nx + longint'(ey) * ny + longint'(ez) * nz;
		if (dot < 0)
			d = 0;
		else if (dot > longint'(full))
			d = full;
		else
			d = dot;
		c = (2 * VFB >= 30) ? d >> (2 * VFB - 30) : d << (30 - 2 * VFB);
		if (n1 > n2) begin
			s = one - ((c * c) >> 30);
			num = n1 * n1 * s;
			lim = (n2 * n2) << 30;
			if (num > lim) begin
				r.refl = fsr_pkg::REFL_ONE;
				r.tir = 1'b1;
				return r;
			end
			sin2 = (n2 == 0) ? 0 : num / (n2 * n2);
			if (sin2 > one)
				sin2 = one;
			c = int_sqrt((one - sin2) << 30);
			if (c > one)
				c = one;
		end
		diff = (n1 > n2) ? n1 - n2 : n2 - n1;
		sum = n1 + n2;
		if (sum == 0) begin
			r0 = 0;
		end else begin
			q = (diff << 30) / sum;
			r0 = (q * q) >> 30;
		end
		x = one - c;
		p = x;
		for (int i = 0; i < 4; i++)
			p = (p * x) >> 30;
		res = r0 + (((one - r0) * p) >> 30);
		res = (res + (64'd1 << 14)) >> 15;
		if (res > 32768)
			res = 32768;
		r.refl = res[15:0];
		r.tir = 1'b0;
		return r;
	endfunction

	// check each done beat against the oldest prediction
	always @(posedge clk) begin
		refl_beat_t e;
		if (arst_n && done) begin
			if (expected_refl.size() == 0) begin
				$error("unexpected result beat: reflectance %0d total_internal %0b",
					reflectance, total_internal);
				errors++;
			end else begin
				e = expected_refl.pop_front();
				if (reflectance !== e.refl) begin
					$error("reflectance: expected %0d, got %0d", e.refl, reflectance);
					errors++;
				end
				if (total_internal !== e.tir) begin
					$error("total_internal: expected %0b, got %0b", e.tir, total_internal);
					errors++;
				end
			end
		end
	end

	task automatic send_sample(
		logic signed [15:0] ex, logic signed [15:0] ey, logic signed [15:0] ez,
		logic signed [15:0] nx, logic signed [15:0] ny, logic signed [15:0] nz,
		logic [14:0] nfrom, logic [14:0] nto, int gap);
		// idle between beats; a zero gap keeps start high back to back
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		eye_x <= ex; eye_y <= ey; eye_z <= ez;
		normal_x <= nx; normal_y <= ny; normal_z <= nz;
		index_from <= nfrom; index_to <= nto;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_refl.insert(expected_refl.size(),
			schlick_reflectance(ex, ey, ez, nx, ny, nz, nfrom, nto));
	endtask

	function automatic logic signed [15:0] rand_comp();
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic [14:0] rand_index();
		// mostly realistic indices, sometimes up to the 15-bit maximum
		if ($urandom_range(0, 3) == 0)
			return 15'($urandom_range(4096, 32767));
		return 15'($urandom_range(4096, 10240));
	endfunction

	task automatic test_directed();
		send_sample(16384, 0, 0, 16384, 0, 0, 4096, 6144, 0);
		send_sample(16384, 0, 0, -16384, 0, 0, 4096, 6144, 1);
		send_sample(0, 16384, 0, 0, 16384, 0, 6144, 4096, 0);
		send_sample(0, 0, 16384, 0, 0, 16384, 32767, 32767, 0);
		send_sample(-16384, -16384, -16384, -16384, -16384, -16384, 4096, 32767, 0);
		send_sample(16384, 16384, 16384, 16384, 16384, 16384, 32767, 4096, 2);
		send_sample(0, 0, 0, 0, 0, 0, 6144, 4096, 0);
		send_sample(0, 0, 0, 0, 0, 0, 4096, 6144, 0);
		send_sample(4096, 0, 0, 16384, 0, 0, 6144, 4096, 0);
		send_sample(15000, 0, 0, 16384, 0, 0, 6144, 4096, 0);
		send_sample(11585, 11585, 0, 16384, 0, 0, 5461, 4096, 3);
		send_sample(-1, -1, -1, 1, 1, 1, 4096, 4096, 0);
		send_sample(16384, 0, 0, 16384, 0, 0, 32767, 4096, 0);
		send_sample(-16384, 16384, -16384, 16384, -16384, 16384, 4096, 4096, 0);
		send_sample(21, 16384, 0, 0, 16384, 0, 4096, 32767, 7);
	endtask

	task automatic test_random();
		logic [14:0] a, b;
		logic signed [15:0] nx, ny, nz;
		for (int i = 0; i < 850; i++) begin
			a = rand_index();
			b = rand_index();
			nx = rand_comp(); ny = rand_comp(); nz = rand_comp();
			// burst phase with no idling
			if ((i / 100) % 3 == 1)
				send_sample(rand_comp(), rand_comp(), rand_comp(), nx, ny, nz, a, b, 0);
			else if ($urandom_range(0, 1))
				// eye near the normal so the cosine lands in range
				send_sample(nx + 16'($urandom_range(0, 512)) - 16'sd256, ny, nz,
					nx, ny, nz, a, b, $urandom_range(0, 7));
			else
				send_sample(rand_comp(), rand_comp(), rand_comp(), nx, ny, nz, a, b,
					$urandom_range(0, 7));
		end
		start <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		eye_x = 0; eye_y = 0; eye_z = 0;
		normal_x = 0; normal_y = 0; normal_z = 0;
		index_from = 15'd4096; index_to = 15'd4096;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		while (expected_refl.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_fresnel_schlick_reflectance_top: done, clean");
		else
			$display("tb_fresnel_schlick_reflectance_top: done, errors");
		$finish;
	end

endmodule
